// ----- design/byte_stuffing_frame_encoder_assert.svh -----
// assertion macros used by the encoder slot module
`ifndef BYTE_STUFFING_FRAME_ENCODER_ASSERT_SVH
`define BYTE_STUFFING_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BSFE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsfe assertion failed");

// next-cycle implication, checked out of reset
`define BSFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsfe assertion failed");

`endif

// ----- design/bsfe_pkg.sv -----
package bsfe_pkg;

   localparam logic [7:0] FLAG_BYTE   = 8'h7E;
   localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
   localparam logic [7:0] ESCAPE_XOR  = 8'h20;

   localparam int unsigned MAX_BYTES = 4;
   localparam int unsigned IDX_W     = $clog2(MAX_BYTES);

   // all line bytes caused by one request, in order from index 0
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [IDX_W-1:0]          last_idx;
   } bsfe_burst_type;

   // one line byte handed from the sequencer to the output register
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } bsfe_byte_type;

endpackage

// ----- design/byte_stuffing_frame_encoder.sv -----
// channel   direction  tdata         tlast          tuser
// req_      in         payload_byte  last_of_frame  [0] first_of_frame, [1] empty_frame
// rsp_      out        line_byte     run_end        -
//
// a request is expanded into 1 to 4 line bytes held in one slot register; the slot
// sends one byte per cycle into the output register unless rsp_tready holds it,
// and the next request loads as the last one leaves.
// reset clears the slot and output valid flags; no memory, no clearing pass.
// rsp_tready low with a full output register holds it and the slot; req_tready follows.
module byte_stuffing_frame_encoder
   import bsfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] payload_byte
   input  logic       req_tlast,
   input  logic [1:0] req_tuser,   // [0] first_of_frame, [1] empty_frame
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] line_byte
   output logic       rsp_tlast
);

   bsfe_burst_type burst;
   bsfe_byte_type  cur_byte;
   logic           slot_free;
   logic           load;
   logic           byte_take;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_data_ff, out_data_in;
   logic       out_last_ff, out_last_in;

   bsfe_expand u_expand (
      .payload_byte   (req_tdata),
      .first_of_frame (req_tuser[0]),
      .last_of_frame  (req_tlast),
      .empty_frame    (req_tuser[1]),
      .burst          (burst)
   );

   assign byte_take  = cur_byte.valid && (!out_valid_ff || rsp_tready);
   assign req_tready = slot_free;
   assign load       = req_tvalid && slot_free;

   bsfe_slot u_slot (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .burst     (burst),
      .byte_take (byte_take),
      .slot_free (slot_free),
      .cur_byte  (cur_byte)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (byte_take) begin
         out_valid_in = 1'b1;
         out_data_in  = cur_byte.data;
         out_last_in  = cur_byte.last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- design/bsfe_expand.sv -----
module bsfe_expand
   import bsfe_pkg::*;
(
   input  logic [7:0]     payload_byte,
   input  logic           first_of_frame,
   input  logic           last_of_frame,
   input  logic           empty_frame,
   output bsfe_burst_type burst
);

   logic [IDX_W-1:0] pos;
   logic             needs_escape;

   assign needs_escape = (payload_byte == FLAG_BYTE) || (payload_byte == ESCAPE_BYTE);

   always_comb begin
      burst = '0;
      pos   = '0;
      if (empty_frame) begin
         burst.bytes[0] = FLAG_BYTE;
         burst.bytes[1] = FLAG_BYTE;
         burst.last_idx = IDX_W'(1);
      end else begin
         if (first_of_frame) begin
            burst.bytes[pos] = FLAG_BYTE;
            pos              = pos + IDX_W'(1);
         end
         if (needs_escape) begin
            burst.bytes[pos] = ESCAPE_BYTE;
            pos              = pos + IDX_W'(1);
            burst.bytes[pos] = payload_byte ^ ESCAPE_XOR;
         end else begin
            burst.bytes[pos] = payload_byte;
         end
         burst.last_idx = pos;
         if (last_of_frame) begin
            // with the opening mark and an escape this lands on the top index
            pos              = pos + IDX_W'(1);
            burst.bytes[pos] = FLAG_BYTE;
            burst.last_idx   = pos;
         end
      end
   end

endmodule

// ----- design/bsfe_slot.sv -----
`include "byte_stuffing_frame_encoder_assert.svh"

module bsfe_slot
   import bsfe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  bsfe_burst_type burst,
   input  logic           byte_take,
   output logic           slot_free,
   output bsfe_byte_type  cur_byte
);

   logic             slot_valid_ff, slot_valid_in;
   bsfe_burst_type   burst_ff, burst_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic             at_last;

   assign at_last   = (index_ff == burst_ff.last_idx);
   // the slot frees up in the same cycle its final byte moves on
   assign slot_free = !slot_valid_ff || (byte_take && at_last);

   assign cur_byte.valid = slot_valid_ff;
   assign cur_byte.data  = burst_ff.bytes[index_ff];
   assign cur_byte.last  = at_last;

   always_comb begin
      slot_valid_in = slot_valid_ff;
      burst_in      = burst_ff;
      index_in      = index_ff;
      if (load) begin
         slot_valid_in = 1'b1;
         burst_in      = burst;
         index_in      = '0;
      end else if (byte_take) begin
         if (at_last) begin
            slot_valid_in = 1'b0;
         end else begin
            index_in = index_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         index_ff      <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         index_ff      <= index_in;
      end
      burst_ff <= burst_in;
   end

   `BSFE_ASSERT_NOW(a_index_in_range, clock, reset, slot_valid_ff, index_ff <= burst_ff.last_idx)
   `BSFE_ASSERT_NEXT(a_load_fills, clock, reset, load, slot_valid_ff && index_ff == '0)
   `BSFE_ASSERT_NEXT(a_stall_holds, clock, reset, slot_valid_ff && !byte_take && !load,
                     slot_valid_ff && $stable(index_ff))
   `BSFE_ASSERT_NOW(a_no_load_busy, clock, reset, load, slot_free)

endmodule

// ----- verif/byte_stuffing_frame_encoder_tb.sv -----
module byte_stuffing_frame_encoder_tb
   import bsfe_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       run_end;
   } line_entry_type;

   class line_byte_scoreboard;
      line_entry_type line_bytes_due[$];
      int unsigned mismatches = 0;

      // expands one accepted request into the line bytes it must cause
      function void encode_request(input logic [7:0] payload, input logic first,
                                   input logic last, input logic empty);
         logic [7:0]     burst[$];
         line_entry_type entry;
         if (empty) begin
            burst.push_back(FLAG_BYTE);
            burst.push_back(FLAG_BYTE);
         end else begin
            if (first) burst.push_back(FLAG_BYTE);
            if (payload == FLAG_BYTE || payload == ESCAPE_BYTE) begin
               burst.push_back(ESCAPE_BYTE);
               burst.push_back(payload ^ ESCAPE_XOR);
            end else begin
               burst.push_back(payload);
            end
            if (last) burst.push_back(FLAG_BYTE);
         end
         foreach (burst[i]) begin
            entry.line_byte = burst[i];
            entry.run_end   = (i == burst.size() - 1);
            line_bytes_due.push_back(entry);
         end
      endfunction

      function void check_line_byte(input logic [7:0] data, input logic last);
         line_entry_type due;
         if (line_bytes_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected line byte: expected none, actual %02h run_end %0b",
                     $time, data, last);
            return;
         end
         due = line_bytes_due.pop_front();
         if (data !== due.line_byte) begin
            mismatches++;
            $display("%0t: line_byte mismatch: expected %02h, actual %02h",
                     $time, due.line_byte, data);
         end
         if (last !== due.run_end) begin
            mismatches++;
            $display("%0t: run_end mismatch: expected %0b, actual %0b",
                     $time, due.run_end, last);
         end
      endfunction

      function int unsigned pending();
         return line_bytes_due.size();
      endfunction
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic [1:0] req_tuser  = 2'b00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   line_byte_scoreboard board = new;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned requests_sent = 0;
   int unsigned cycle_count   = 0;

   byte_stuffing_frame_encoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_line_byte(rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // valid stays high between back-to-back requests; it only drops for an idle gap or a drain
   task automatic send_request(input logic [7:0] payload, input logic first,
                               input logic last, input logic empty);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= payload;
      req_tlast  <= last;
      req_tuser  <= {empty, first};
      do @(posedge clock); while (!req_tready);
      board.encode_request(payload, first, last, empty);
      requests_sent++;
   endtask

   task automatic drain_line_bytes();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // leans toward the bytes that need escaping and their neighbors
   function automatic logic [7:0] pick_payload();
      case ($urandom_range(9))
         0, 1:    return FLAG_BYTE;
         2:       return ESCAPE_BYTE;
         3:       return 8'h7C + 8'($urandom_range(3));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_frame();
      int unsigned len;
      len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
      if (len == 0) begin
         send_request(8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'b1);
      end else begin
         for (int unsigned i = 0; i < len; i++)
            send_request(pick_payload(), i == 0, i == len - 1, 1'b0);
      end
   endtask

   task automatic send_random_until(input int unsigned target);
      while (requests_sent < target) begin
         if ($urandom_range(99) < 80) begin
            send_frame();
         end else begin
            // broken or out-of-order marks
            send_request(pick_payload(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                         $urandom_range(9) == 0);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 22;
      recv_idle_pct = 52;

      // escaped bytes inside single-byte frames give the longest bursts
      send_request(FLAG_BYTE,   1'b1, 1'b1, 1'b0);
      send_request(ESCAPE_BYTE, 1'b1, 1'b1, 1'b0);
      // a frame walking the field extremes and the escape neighborhood
      send_request(8'h00, 1'b1, 1'b0, 1'b0);
      send_request(8'hFF, 1'b0, 1'b0, 1'b0);
      send_request(8'h5E, 1'b0, 1'b0, 1'b0);
      send_request(8'h5D, 1'b0, 1'b0, 1'b0);
      send_request(8'h7C, 1'b0, 1'b0, 1'b0);
      send_request(8'h7F, 1'b0, 1'b0, 1'b0);
      send_request(FLAG_BYTE,   1'b0, 1'b0, 1'b0);
      send_request(ESCAPE_BYTE, 1'b0, 1'b0, 1'b0);
      send_request(8'h01, 1'b0, 1'b1, 1'b0);
      // empty frames ignore payload and marks
      send_request(FLAG_BYTE, 1'b1, 1'b1, 1'b1);
      send_request(8'h00, 1'b0, 1'b0, 1'b1);
      send_request(8'hFF, 1'b1, 1'b0, 1'b1);
      send_request(ESCAPE_BYTE, 1'b0, 1'b1, 1'b1);
      // two opening marks in a row
      send_request(8'h11, 1'b1, 1'b0, 1'b0);
      send_request(8'h22, 1'b1, 1'b0, 1'b0);
      send_request(8'h33, 1'b0, 1'b1, 1'b0);
      // unclosed frame followed by a byte with no opening mark
      send_request(8'h44, 1'b1, 1'b0, 1'b0);
      send_request(8'hAA, 1'b0, 1'b0, 1'b0);
      send_request(8'h55, 1'b0, 1'b0, 1'b0);
      send_request(ESCAPE_BYTE, 1'b0, 1'b1, 1'b0);
      send_request(8'h80, 1'b0, 1'b1, 1'b0);

      send_random_until(120);

      // hold off the sender until the encoder has emptied
      drain_line_bytes();

      send_idle_pct = 52;
      recv_idle_pct = 22;
      send_random_until(220);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_until(320);

      drain_line_bytes();
      repeat (16) @(posedge clock);

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+design
design/bsfe_pkg.sv
design/bsfe_expand.sv
design/bsfe_slot.sv
design/byte_stuffing_frame_encoder.sv
verif/byte_stuffing_frame_encoder_tb.sv
